>>> hdl/teq_pkg.sv
// Shared types and constants for the time-sorted event queue.
// No dependencies.
`default_nettype none
package teq_pkg;

   localparam int DEFAULT_CAPACITY = 32;

   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 16;
   localparam int TIME_W   = 32;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 6;

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LIST   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] STS_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] STS_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] STS_CLEARED  = 3'd2;
   localparam logic [STATUS_W-1:0] STS_LISTED   = 3'd3;
   localparam logic [STATUS_W-1:0] STS_EMPTY    = 3'd4;

   // per-cell load control
   typedef struct packed {
      logic load_new;   // take the incoming event
      logic shift;      // take the left neighbor (insert makes room)
      logic rotate;     // read-out step: take the right neighbor
      logic wrap;       // last occupied cell, or last cell of the chain: take cell 0 on rotate
   } cell_ctl_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_LIST = 2'b10
   } state_type;

endpackage
`default_nettype wire

>>> hdl/time_sorted_event_queue_unit.sv
// Top level of the time-sorted event queue: a chain of teq_cell instances
// plus occupancy, read-out sequencing and the result register. Uses teq_pkg.
// Insert and clear: result registered in the cycle after start, a new transaction each
// cycle while not busy. Read-out: busy while the entries are read out; entries appear
// one per cycle as the chain rotates. Empty read-out: result in the cycle after start.
// Synchronous reset empties the store; slot contents are not cleared.
`default_nettype none
module time_sorted_event_queue_unit #(
   parameter int CAPACITY = teq_pkg::DEFAULT_CAPACITY
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [teq_pkg::ACTION_W-1:0] req_action,
   input  wire logic [teq_pkg::INDEX_W-1:0]  req_spike_index,
   input  wire logic [teq_pkg::TIME_W-1:0]   req_spike_time,
   output logic                             rsp_strobe,
   output logic [teq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [teq_pkg::INDEX_W-1:0]       rsp_entry_index,
   output logic [teq_pkg::TIME_W-1:0]        rsp_entry_time,
   output logic [teq_pkg::COUNT_W-1:0]       rsp_entry_count,
   output logic                             rsp_last
);
   import teq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   occ_ff, occ_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [TIME_W-1:0]   rsp_time_ff, rsp_time_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [INDEX_W-1:0] cell_index [CAPACITY];
   logic [TIME_W-1:0]  cell_time  [CAPACITY];
   logic [CAPACITY-1:0] cell_le;
   logic [CAPACITY-1:0] cell_valid;
   cell_ctl_type        cell_ctl [CAPACITY];

   logic accept, full, front, ins_go, rot_go;
   logic [CNT_W+COUNT_W-1:0] count_wide;

   assign busy   = (state_ff == S_LIST);
   assign accept = start && !busy;
   assign full   = (occ_ff >= CNT_W'(CAPACITY));
   assign front  = (occ_ff == '0) || (req_spike_time <= cell_time[0]);
   assign ins_go = accept && (req_action == ACT_INSERT) && !full;
   assign rot_go = (state_ff == S_LIST);

   always_comb begin
      logic keep, prev_keep;
      for (int i = 0; i < CAPACITY; i++) begin
         cell_valid[i] = (CNT_W'(i) < occ_ff);
         keep      = !front && cell_le[i];
         prev_keep = (i == 0) ? 1'b1 : (!front && cell_le[(i == 0) ? 0 : i - 1]);
         cell_ctl[i].load_new = ins_go && !keep && prev_keep;
         cell_ctl[i].shift    = ins_go && !keep && !prev_keep;
         cell_ctl[i].rotate   = rot_go;
         cell_ctl[i].wrap     = (CNT_W'(i + 1) == occ_ff) || (i == CAPACITY - 1);
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      localparam int L = (g == 0) ? 0 : g - 1;
      localparam int R = (g == CAPACITY - 1) ? 0 : g + 1;
      teq_cell u_cell (
         .clock       (clock),
         .ctl         (cell_ctl[g]),
         .cell_valid  (cell_valid[g]),
         .cmp_time    (req_spike_time),
         .new_index   (req_spike_index),
         .new_time    (req_spike_time),
         .left_index  (cell_index[L]),
         .left_time   (cell_time[L]),
         .right_index (cell_index[R]),
         .right_time  (cell_time[R]),
         .first_index (cell_index[0]),
         .first_time  (cell_time[0]),
         .index_q     (cell_index[g]),
         .time_q      (cell_time[g]),
         .le          (cell_le[g])
      );
   end

   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      rem_in        = rem_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = STS_INSERTED;
      rsp_index_in  = '0;
      rsp_time_in   = '0;
      rsp_count_in  = occ_ff;
      rsp_last_in   = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_INSERT: begin
                     rsp_strobe_in = 1'b1;
                     if (full) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        occ_in        = occ_ff + CNT_W'(1);
                        rsp_count_in  = occ_ff + CNT_W'(1);
                        rsp_status_in = STS_INSERTED;
                     end
                  end
                  ACT_LIST: begin
                     if (occ_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STS_EMPTY;
                     end else begin
                        rem_in   = occ_ff;
                        state_in = S_LIST;
                     end
                  end
                  ACT_CLEAR: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STS_CLEARED;
                     occ_in        = '0;
                     rsp_count_in  = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_LIST: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = STS_LISTED;
            rsp_index_in  = cell_index[0];
            rsp_time_in   = cell_time[0];
            rsp_last_in   = (rem_ff == CNT_W'(1));
            rem_in        = rem_ff - CNT_W'(1);
            if (rem_ff == CNT_W'(1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         occ_ff        <= '0;
         rem_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         rem_ff        <= rem_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign count_wide      = {{COUNT_W{1'b0}}, rsp_count_ff};
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_index = rsp_index_ff;
   assign rsp_entry_time  = rsp_time_ff;
   assign rsp_entry_count = count_wide[COUNT_W-1:0];
   assign rsp_last        = rsp_last_ff;

endmodule
`default_nettype wire

>>> hdl/teq_cell.sv
// One storage cell of the sorted event chain: holds one event, compares it
// against an incoming time and loads the new event or a neighbor's. Uses teq_pkg.
`default_nettype none
module teq_cell (
   input  wire logic                       clock,
   input  wire teq_pkg::cell_ctl_type      ctl,
   input  wire logic                       cell_valid,
   input  wire logic [teq_pkg::TIME_W-1:0]  cmp_time,
   input  wire logic [teq_pkg::INDEX_W-1:0] new_index,
   input  wire logic [teq_pkg::TIME_W-1:0]  new_time,
   input  wire logic [teq_pkg::INDEX_W-1:0] left_index,
   input  wire logic [teq_pkg::TIME_W-1:0]  left_time,
   input  wire logic [teq_pkg::INDEX_W-1:0] right_index,
   input  wire logic [teq_pkg::TIME_W-1:0]  right_time,
   input  wire logic [teq_pkg::INDEX_W-1:0] first_index,
   input  wire logic [teq_pkg::TIME_W-1:0]  first_time,
   output logic [teq_pkg::INDEX_W-1:0]      index_q,
   output logic [teq_pkg::TIME_W-1:0]       time_q,
   output logic                             le
);
   import teq_pkg::*;

   logic [INDEX_W-1:0] index_ff, index_in;
   logic [TIME_W-1:0]  time_ff, time_in;

   always_comb begin
      index_in = index_ff;
      time_in  = time_ff;
      if (ctl.load_new) begin
         index_in = new_index;
         time_in  = new_time;
      end else if (ctl.shift) begin
         index_in = left_index;
         time_in  = left_time;
      end else if (ctl.rotate) begin
         if (ctl.wrap) begin
            index_in = first_index;
            time_in  = first_time;
         end else begin
            index_in = right_index;
            time_in  = right_time;
         end
      end
   end

   always_ff @(posedge clock) begin
      index_ff <= index_in;
      time_ff  <= time_in;
   end

   assign index_q = index_ff;
   assign time_q  = time_ff;
   assign le      = cell_valid && (time_ff <= cmp_time);

endmodule
`default_nettype wire

>>> test/teq_event_checker.sv
// Checker for the time-sorted event queue: mirrors the sorted store, predicts every
// result of each accepted transaction and compares it with what the block returns.
// Depends on teq_pkg.
module teq_event_checker #(
   parameter int CAPACITY = teq_pkg::DEFAULT_CAPACITY
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [teq_pkg::ACTION_W-1:0]  req_action,
   input  logic [teq_pkg::INDEX_W-1:0]   req_spike_index,
   input  logic [teq_pkg::TIME_W-1:0]    req_spike_time,
   input  logic                          rsp_strobe,
   input  logic [teq_pkg::STATUS_W-1:0]  rsp_status,
   input  logic [teq_pkg::INDEX_W-1:0]   rsp_entry_index,
   input  logic [teq_pkg::TIME_W-1:0]    rsp_entry_time,
   input  logic [teq_pkg::COUNT_W-1:0]   rsp_entry_count,
   input  logic                          rsp_last,
   output int                            mismatches,
   output int                            outstanding
);
   import teq_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  index;
      logic [TIME_W-1:0]   tstamp;
      logic [COUNT_W-1:0]  count;
      logic                is_last;
   } rsp_item_type;

   logic [INDEX_W-1:0] mirror_idx [CAPACITY];
   logic [TIME_W-1:0]  mirror_time [CAPACITY];
   int                 mirror_fill = 0;
   rsp_item_type       due_rsp [$];
   int                 err_count = 0;

   initial begin
      mismatches = 0;
      outstanding = 0;
   end

   task automatic push_due(input logic [STATUS_W-1:0] st, input logic [INDEX_W-1:0] ix,
                           input logic [TIME_W-1:0] tm, input int cnt, input logic lst);
      rsp_item_type r;
      r.status  = st;
      r.index   = ix;
      r.tstamp  = tm;
      r.count   = cnt[COUNT_W-1:0];
      r.is_last = lst;
      due_rsp.push_back(r);
   endtask

   task automatic sorted_store_step(input logic [ACTION_W-1:0] act,
                                    input logic [INDEX_W-1:0] ix,
                                    input logic [TIME_W-1:0] tm);
      int pos;
      int i;
      case (act)
         ACT_INSERT: begin
            if (mirror_fill >= CAPACITY) begin
               push_due(STS_FULL, '0, '0, mirror_fill, 1'b1);
            end else begin
               pos = 0;
               // at or below the front goes first, otherwise after the last entry <= tm
               if (mirror_fill != 0 && tm > mirror_time[0]) begin
                  for (i = 0; i < mirror_fill; i++) begin
                     if (mirror_time[i] <= tm) pos = i + 1;
                  end
               end
               for (i = mirror_fill; i > pos; i--) begin
                  mirror_idx[i]  = mirror_idx[i-1];
                  mirror_time[i] = mirror_time[i-1];
               end
               mirror_idx[pos]  = ix;
               mirror_time[pos] = tm;
               mirror_fill++;
               push_due(STS_INSERTED, '0, '0, mirror_fill, 1'b1);
            end
         end
         ACT_LIST: begin
            if (mirror_fill == 0) begin
               push_due(STS_EMPTY, '0, '0, 0, 1'b1);
            end else begin
               for (i = 0; i < mirror_fill; i++) begin
                  push_due(STS_LISTED, mirror_idx[i], mirror_time[i], mirror_fill,
                           i + 1 == mirror_fill);
               end
            end
         end
         ACT_CLEAR: begin
            mirror_fill = 0;
            push_due(STS_CLEARED, '0, '0, 0, 1'b1);
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      rsp_item_type want;
      if (reset) begin
         mirror_fill = 0;
         due_rsp.delete();
      end else begin
         if (rsp_strobe !== 1'b0) begin
            if (due_rsp.size() == 0) begin
               if (err_count < 10)
                  $display("unexpected result: status %0d index %h time %h count %0d last %0b",
                           rsp_status, rsp_entry_index, rsp_entry_time, rsp_entry_count,
                           rsp_last);
               err_count++;
            end else begin
               want = due_rsp.pop_front();
               if (rsp_status !== want.status || rsp_entry_index !== want.index ||
                   rsp_entry_time !== want.tstamp || rsp_entry_count !== want.count ||
                   rsp_last !== want.is_last) begin
                  if (err_count < 10)
                     $display({"result mismatch (exp/got): status %0d/%0d index %h/%h ",
                               "time %h/%h count %0d/%0d last %0b/%0b"},
                              want.status, rsp_status, want.index, rsp_entry_index,
                              want.tstamp, rsp_entry_time, want.count, rsp_entry_count,
                              want.is_last, rsp_last);
                  err_count++;
               end
            end
         end
         if (start && !busy) sorted_store_step(req_action, req_spike_index, req_spike_time);
      end
      mismatches  <= err_count;
      outstanding <= due_rsp.size();
   end

endmodule

>>> test/tb_time_sorted_event_queue_unit.sv
// Testbench top for time_sorted_event_queue_unit: drives directed and random insert,
// read-out and clear transactions with sender gaps and gives the verdict.
// Depends on teq_pkg, time_sorted_event_queue_unit and teq_event_checker.
module tb_time_sorted_event_queue_unit;
   import teq_pkg::*;

   localparam int CAPACITY = DEFAULT_CAPACITY;
   localparam int LIMIT    = 200000;
   localparam int SETTLE   = CAPACITY + 8;
   localparam int ITEMS    = 310;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [ACTION_W-1:0] req_action = ACT_INSERT;
   logic [INDEX_W-1:0]  req_spike_index = '0;
   logic [TIME_W-1:0]   req_spike_time = '0;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [INDEX_W-1:0]  rsp_entry_index;
   logic [TIME_W-1:0]   rsp_entry_time;
   logic [COUNT_W-1:0]  rsp_entry_count;
   logic                rsp_last;
   int                  mismatches;
   int                  outstanding;
   int                  cycles = 0;
   int                  idle_pct = 0;
   int                  sent = 0;

   time_sorted_event_queue_unit #(.CAPACITY(CAPACITY)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_spike_index(req_spike_index),
      .req_spike_time(req_spike_time),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status), .rsp_entry_index(rsp_entry_index),
      .rsp_entry_time(rsp_entry_time), .rsp_entry_count(rsp_entry_count),
      .rsp_last(rsp_last)
   );

   teq_event_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_spike_index(req_spike_index),
      .req_spike_time(req_spike_time),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status), .rsp_entry_index(rsp_entry_index),
      .rsp_entry_time(rsp_entry_time), .rsp_entry_count(rsp_entry_count),
      .rsp_last(rsp_last), .mismatches(mismatches), .outstanding(outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_event(input logic [ACTION_W-1:0] act, input logic [INDEX_W-1:0] ix,
                             input logic [TIME_W-1:0] tm);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_action      <= act;
      req_spike_index <= ix;
      req_spike_time  <= tm;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (act != ACT_UNUSED) sent++;
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [TIME_W-1:0] pick_time();
      int sel;
      sel = $urandom_range(9);
      if (sel < 4) return $urandom_range(7);
      if (sel == 4) return '0;
      if (sel == 5) return '1;
      return $urandom();
   endfunction

   function automatic logic [INDEX_W-1:0] pick_index();
      int sel;
      sel = $urandom_range(9);
      if (sel == 0) return '0;
      if (sel == 1) return '1;
      return INDEX_W'($urandom());
   endfunction

   initial begin : stimulus
      int n;
      int k;
      int sel;
      int phase;
      bit first;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      send_event(ACT_LIST,   16'h0000, 32'h0000_0000);
      send_event(ACT_INSERT, 16'h1234, 32'h0001_0000);
      send_event(ACT_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
      send_event(ACT_INSERT, 16'h0000, 32'h0000_0000);
      send_event(ACT_INSERT, 16'h0A0A, 32'h0000_0000);
      send_event(ACT_INSERT, 16'h5555, 32'h0001_0000);
      send_event(ACT_INSERT, 16'hAAAA, 32'hFFFF_FFFF);
      send_event(ACT_INSERT, 16'h00FF, 32'h8000_0000);
      send_event(ACT_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
      send_event(ACT_LIST,   16'h0000, 32'h0000_0000);
      send_event(ACT_CLEAR,  16'hFFFF, 32'hFFFF_FFFF);
      send_event(ACT_LIST,   16'h0000, 32'h0000_0000);
      send_event(ACT_CLEAR,  16'h0000, 32'h0000_0000);
      send_event(ACT_INSERT, 16'h0001, 32'h0000_0003);
      send_event(ACT_LIST,   16'h0000, 32'h0000_0000);
      drain_results();

      // random episodes: often a clear, mixed actions (mostly inserts), a read-out
      phase = 0;
      first = 1'b1;
      idle_pct = 11;
      while (sent < ITEMS) begin
         if (phase == 0 && sent >= ITEMS / 3) begin
            drain_results();
            phase = 1;
            idle_pct = 69;
         end else if (phase == 1 && sent >= 2 * ITEMS / 3) begin
            drain_results();
            phase = 2;
            idle_pct = 0;
         end
         if (first || $urandom_range(3) != 0)
            send_event(ACT_CLEAR, pick_index(), pick_time());
         n = first ? CAPACITY + 3 : ($urandom_range(4) == 0 ? $urandom_range(CAPACITY, CAPACITY + 4)
                                                             : $urandom_range(1, 12));
         first = 1'b0;
         for (k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            if (sel < 8)
               send_event(ACT_LIST, pick_index(), pick_time());
            else if (sel < 12)
               send_event(ACT_UNUSED, pick_index(), pick_time());
            else if (sel < 14)
               send_event(ACT_CLEAR, pick_index(), pick_time());
            else
               send_event(ACT_INSERT, pick_index(), pick_time());
         end
         send_event(ACT_LIST, pick_index(), pick_time());
      end

      drain_results();
      if (mismatches == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> time_sorted_event_queue_unit.f
hdl/teq_pkg.sv
hdl/teq_cell.sv
hdl/time_sorted_event_queue_unit.sv
test/teq_event_checker.sv
test/tb_time_sorted_event_queue_unit.sv
